FILE: hdl/brf_pkg.sv
package brf_pkg;

	localparam int ADDR_W = 8;
	localparam int DATA_W = 8;
	localparam int MAX_SLOTS = 256;
	localparam logic [ADDR_W-1:0] RING_SIZE_RST = 8'd255;
	localparam logic [ADDR_W-1:0] RING_SIZE_MIN = 8'd2;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_PEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [DATA_W-1:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] data_out;
		logic              is_empty;
		logic              is_full;
		logic [ADDR_W-1:0] used_count;
		logic [ADDR_W-1:0] free_count;
		logic              overflow_seen;
	} rsp_t;

	// memory access request from the control unit
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// status of one operation, valid in the cycle after acceptance
	typedef struct packed {
		logic              valid;
		logic              ok;
		logic              rd;
		logic              is_empty;
		logic              is_full;
		logic [ADDR_W-1:0] used_count;
		logic [ADDR_W-1:0] free_count;
		logic              overflow_seen;
	} stat_t;

	// pointer step inside a ring of size slots (p < size)
	function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p,
			input logic [ADDR_W-1:0] size);
		logic [ADDR_W:0] n;
		n = {1'b0, p} + {{ADDR_W{1'b0}}, 1'b1};
		if (n == {1'b0, size}) begin
			return '0;
		end
		return n[ADDR_W-1:0];
	endfunction

endpackage

FILE: hdl/brf_ram.sv
module brf_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/brf_ctrl.sv
module brf_ctrl import brf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  cmd_t              cmd,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_data,
	output mem_req_t          mem_req,
	output stat_t             stat
);

	logic [ADDR_W-1:0] wp_q, rp_q, size_q;
	logic              ovf_q;

	logic [ADDR_W-1:0] size_eff, wp_inc, rp_inc, wp_n, rp_n, diff, used, free;
	logic              ovf_n, ok, rd, has_data, full_now;

	stat_t stat_s1;

	assign size_eff = (size_q < RING_SIZE_MIN) ? RING_SIZE_MIN : size_q;
	assign wp_inc   = ring_next(wp_q, size_eff);
	assign rp_inc   = ring_next(rp_q, size_eff);
	assign has_data = (wp_q != rp_q);
	assign full_now = (wp_inc == rp_q);

	always_comb begin
		wp_n  = wp_q;
		rp_n  = rp_q;
		ovf_n = ovf_q;
		ok    = 1'b0;
		rd    = 1'b0;
		case (cmd.op)
			OP_PUSH: begin
				if (full_now) begin
					ovf_n = 1'b1;
				end else begin
					wp_n = wp_inc;
					ok   = 1'b1;
				end
			end
			OP_POP: begin
				if (has_data) begin
					rp_n = rp_inc;
					ok   = 1'b1;
					rd   = 1'b1;
				end
			end
			OP_PEEK: begin
				if (has_data) begin
					ok = 1'b1;
					rd = 1'b1;
				end
			end
			OP_CLEAR: begin
				wp_n  = '0;
				rp_n  = '0;
				ovf_n = 1'b0;
				ok    = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// occupancy after the operation; wrap case adds the ring size mod 256
	assign diff = wp_n - rp_n;
	assign used = (wp_n >= rp_n) ? diff : diff + size_eff;
	assign free = size_eff - 8'd1 - used;

	assign mem_req.we    = accept && (cmd.op == OP_PUSH) && !full_now;
	assign mem_req.waddr = wp_q;
	assign mem_req.wdata = cmd.data_in;
	assign mem_req.re    = accept && rd;
	assign mem_req.raddr = rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			ovf_q   <= 1'b0;
			size_q  <= RING_SIZE_RST;
			stat_s1 <= '0;
		end else begin
			stat_s1.valid <= accept;
			if (cfg_we) begin
				size_q <= cfg_data;
				wp_q   <= '0;
				rp_q   <= '0;
				ovf_q  <= 1'b0;
			end else if (accept) begin
				wp_q  <= wp_n;
				rp_q  <= rp_n;
				ovf_q <= ovf_n;
			end
			if (accept) begin
				stat_s1.ok            <= ok;
				stat_s1.rd            <= rd;
				stat_s1.is_empty      <= (wp_n == rp_n);
				stat_s1.is_full       <= (ring_next(wp_n, size_eff) == rp_n);
				stat_s1.used_count    <= used;
				stat_s1.free_count    <= free;
				stat_s1.overflow_seen <= ovf_n;
			end
		end
	end

	assign stat = stat_s1;

endmodule

FILE: hdl/byte_ring_fifo.sv
// Byte FIFO on a circular store of ring_size slots (one slot always left
// empty, so at most ring_size-1 bytes are held). A command (push, pop, peek
// or clear) is taken at a clock edge where start is high and busy is low;
// one command can be taken every clock while busy is low. Its result
// appears on rsp in the next cycle, flagged by result_valid for that
// single cycle. There is no back pressure on the result side: capture
// it when result_valid is high. Status and read data are both registered.
// busy is high only while a cfg write is offered; a cfg write sets the
// ring size and also empties the FIFO and clears the overflow flag.
// Sizes 0 and 1 act as 2. Write cfg only when no result is still due.
module byte_ring_fifo import brf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	output logic              result_valid,
	output rsp_t              rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ADDR_W-1:0] cfg_data
);

	logic     accept;
	mem_req_t mem_req;
	stat_t    stat;
	logic [DATA_W-1:0] rdata;

	// cfg transfer always completes at once; it blocks commands that cycle
	assign cfg_ready = 1'b1;
	assign busy      = cfg_valid;
	assign accept    = start && !busy;

	// pointers, flags and status update
	brf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (cmd),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.mem_req (mem_req),
		.stat    (stat)
	);

	// slot store; a push writes at the edge it is taken, so a pop in the
	// very next cycle already reads the new byte
	brf_ram #(
		.AW(ADDR_W),
		.DW(DATA_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.raddr),
		.rdata(rdata)
	);

	assign result_valid      = stat.valid;
	assign rsp.ok            = stat.ok;
	assign rsp.data_out      = stat.rd ? rdata : '0;
	assign rsp.is_empty      = stat.is_empty;
	assign rsp.is_full       = stat.is_full;
	assign rsp.used_count    = stat.used_count;
	assign rsp.free_count    = stat.free_count;
	assign rsp.overflow_seen = stat.overflow_seen;

endmodule

FILE: hdl/brf_checker.sv
module brf_checker import brf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid,
	input rsp_t rsp
);

	// one result per taken command, in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> result_valid)
		else $error("missing result after command transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !result_valid)
		else $error("result without command transfer");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (rsp.is_empty == (rsp.used_count == '0)))
		else $error("empty flag disagrees with used count");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && rsp.is_full) |-> (rsp.free_count == '0 && !rsp.is_empty))
		else $error("full flag disagrees with free count");

	a_fail_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !rsp.ok) |-> (rsp.data_out == '0))
		else $error("failed operation returned data");

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.result_valid(result_valid),
	.rsp         (rsp)
);

FILE: tb/byte_ring_fifo_tb.sv
`timescale 1ns / 1ps

// Byte ring FIFO testbench.
// A scoreboard model of the ring (pointers, sticky overflow, slot contents)
// predicts every response at the edge where the command transfer happens.
// Responses are matched in order against that queue. A short directed table
// comes first, then ring-size phases driven by fill/drain biased traffic.
module byte_ring_fifo_tb;
	import brf_pkg::*;

	localparam int RSP_LAT = 1;        // result in the cycle after the command
	localparam int CYCLE_LIMIT = 300000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	cmd_t              cmd = '0;
	logic              result_valid;
	rsp_t              rsp;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ADDR_W-1:0] cfg_data = '0;

	byte_ring_fifo u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.rsp          (rsp),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Ring model: shadow of the DUT state
	// ------------------------------------------------------------------
	logic [7:0]  ring_mem [MAX_SLOTS];
	int unsigned ring_len = 255;   // raw register value
	int unsigned wr_ptr = 0;
	int unsigned rd_ptr = 0;
	bit          ovf_flag = 1'b0;

	rsp_t pending_rsp [$];         // responses still owed by the DUT
	int   n_fail = 0;
	int   n_cmds = 0;
	int   n_overflows = 0;
	int   n_full = 0;
	int   n_sizes = 0;
	int   cycles = 0;
	bit   steady = 1'b0;           // no random gaps between commands while set

	// sizes 0 and 1 behave as 2; 8-bit register never exceeds the store
	function automatic int unsigned ring_span();
		return (ring_len < 2) ? 2 : ring_len;
	endfunction

	function automatic rsp_t ring_step(input op_t o, input logic [7:0] d);
		rsp_t        r;
		int unsigned span;
		int unsigned held;
		span = ring_span();
		r = '0;
		case (o)
			OP_PUSH: begin
				if ((wr_ptr + 1) % span == rd_ptr) begin
					ovf_flag = 1'b1;
					n_overflows++;
				end else begin
					ring_mem[wr_ptr] = d;
					wr_ptr = (wr_ptr + 1) % span;
					r.ok = 1'b1;
				end
			end
			OP_POP, OP_PEEK: begin
				if (rd_ptr != wr_ptr) begin
					r.data_out = ring_mem[rd_ptr];
					if (o == OP_POP)
						rd_ptr = (rd_ptr + 1) % span;
					r.ok = 1'b1;
				end
			end
			default: begin  // clear: pointers and flag only, bytes stay
				wr_ptr = 0;
				rd_ptr = 0;
				ovf_flag = 1'b0;
				r.ok = 1'b1;
			end
		endcase
		held = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : span - rd_ptr + wr_ptr;
		r.is_empty = (wr_ptr == rd_ptr);
		r.is_full = ((wr_ptr + 1) % span == rd_ptr);
		r.used_count = held[7:0];
		r.free_count = 8'(span - 1 - held);
		r.overflow_seen = ovf_flag;
		if (r.is_full)
			n_full++;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// mostly back to back, some short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// One command transfer. A pinned response replaces the model's answer
	// as the expectation, while the model state still advances.
	task automatic issue_cmd(input op_t o, input logic [7:0] d,
			input bit pinned, input rsp_t pin_rsp);
		rsp_t predicted;
		int   gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= '{op: o, data_in: d};
		do @(posedge clk); while (busy);
		predicted = ring_step(o, d);
		pending_rsp.push_back(pinned ? pin_rsp : predicted);
		n_cmds++;
	endtask

	// sender holds off until every owed response has come back
	task automatic drain();
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (RSP_LAT + 1) @(posedge clk);
	endtask

	// ring size write; the DUT also empties the ring and drops the flag
	task automatic write_ring_size(input logic [7:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ring_len = {24'd0, v};
		wr_ptr = 0;
		rd_ptr = 0;
		ovf_flag = 1'b0;
		n_sizes++;
	endtask

	// ------------------------------------------------------------------
	// Response checker: one result per strobe, no back pressure
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && result_valid) begin
			if (pending_rsp.size() == 0) begin
				$error("response with nothing outstanding: %h", rsp);
				n_fail++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.ok !== e.ok) begin
					$error("ok exp %0d got %0d", e.ok, rsp.ok);
					n_fail++;
				end
				if (rsp.data_out !== e.data_out) begin
					$error("data_out exp %0d got %0d", e.data_out, rsp.data_out);
					n_fail++;
				end
				if (rsp.is_empty !== e.is_empty) begin
					$error("is_empty exp %0d got %0d", e.is_empty, rsp.is_empty);
					n_fail++;
				end
				if (rsp.is_full !== e.is_full) begin
					$error("is_full exp %0d got %0d", e.is_full, rsp.is_full);
					n_fail++;
				end
				if (rsp.used_count !== e.used_count) begin
					$error("used_count exp %0d got %0d", e.used_count, rsp.used_count);
					n_fail++;
				end
				if (rsp.free_count !== e.free_count) begin
					$error("free_count exp %0d got %0d", e.free_count, rsp.free_count);
					n_fail++;
				end
				if (rsp.overflow_seen !== e.overflow_seen) begin
					$error("overflow_seen exp %0d got %0d", e.overflow_seen,
						rsp.overflow_seen);
					n_fail++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("byte_ring_fifo_tb: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	typedef struct {
		bit         is_cfg;   // ring size write instead of a command
		logic [7:0] cfg_val;
		op_t        op;
		logic [7:0] data;
		bit         pinned;   // exp typed in below
		rsp_t       exp;
	} plan_row_t;

	function automatic plan_row_t cmd_row(input op_t o, input logic [7:0] d);
		return '{is_cfg: 1'b0, cfg_val: '0, op: o, data: d, pinned: 1'b0, exp: '0};
	endfunction

	// fields: ok, data_out, is_empty, is_full, used, free, overflow
	function automatic plan_row_t chk_row(input op_t o, input logic [7:0] d,
			input rsp_t x);
		return '{is_cfg: 1'b0, cfg_val: '0, op: o, data: d, pinned: 1'b1, exp: x};
	endfunction

	function automatic plan_row_t cfg_row(input logic [7:0] v);
		return '{is_cfg: 1'b1, cfg_val: v, op: OP_PUSH, data: '0, pinned: 1'b0,
			exp: '0};
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		plan_row_t   plan [$];
		logic [7:0]  phase_size [8];
		int unsigned span;
		int          n_items;
		int          r;
		bit          filling;
		op_t         o;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 255: empty-ring failures, byte extremes, clear
		plan.push_back(chk_row(OP_POP,   8'h00,
			'{1'b0, 8'h00, 1'b1, 1'b0, 8'd0, 8'd254, 1'b0}));
		plan.push_back(chk_row(OP_PEEK,  8'h00,
			'{1'b0, 8'h00, 1'b1, 1'b0, 8'd0, 8'd254, 1'b0}));
		plan.push_back(chk_row(OP_PUSH,  8'h00,
			'{1'b1, 8'h00, 1'b0, 1'b0, 8'd1, 8'd253, 1'b0}));
		plan.push_back(chk_row(OP_PUSH,  8'hFF,
			'{1'b1, 8'h00, 1'b0, 1'b0, 8'd2, 8'd252, 1'b0}));
		plan.push_back(chk_row(OP_PEEK,  8'h00,
			'{1'b1, 8'h00, 1'b0, 1'b0, 8'd2, 8'd252, 1'b0}));
		plan.push_back(chk_row(OP_POP,   8'h00,
			'{1'b1, 8'h00, 1'b0, 1'b0, 8'd1, 8'd253, 1'b0}));
		plan.push_back(chk_row(OP_POP,   8'h00,
			'{1'b1, 8'hFF, 1'b1, 1'b0, 8'd0, 8'd254, 1'b0}));
		plan.push_back(cmd_row(OP_PUSH,  8'hA5));
		plan.push_back(chk_row(OP_CLEAR, 8'hFF,
			'{1'b1, 8'h00, 1'b1, 1'b0, 8'd0, 8'd254, 1'b0}));
		// size 0 acts as 2: one byte fills it, next push overflows
		plan.push_back(cfg_row(8'd0));
		plan.push_back(chk_row(OP_PUSH,  8'h5A,
			'{1'b1, 8'h00, 1'b0, 1'b1, 8'd1, 8'd0, 1'b0}));
		plan.push_back(chk_row(OP_PUSH,  8'h11,
			'{1'b0, 8'h00, 1'b0, 1'b1, 8'd1, 8'd0, 1'b1}));
		plan.push_back(chk_row(OP_PEEK,  8'h00,
			'{1'b1, 8'h5A, 1'b0, 1'b1, 8'd1, 8'd0, 1'b1}));
		plan.push_back(chk_row(OP_POP,   8'h00,
			'{1'b1, 8'h5A, 1'b1, 1'b0, 8'd0, 8'd1, 1'b1}));
		plan.push_back(chk_row(OP_POP,   8'h00,
			'{1'b0, 8'h00, 1'b1, 1'b0, 8'd0, 8'd1, 1'b1}));
		plan.push_back(chk_row(OP_CLEAR, 8'h00,
			'{1'b1, 8'h00, 1'b1, 1'b0, 8'd0, 8'd1, 1'b0}));
		// size 1 acts as 2; leave the overflow flag set for the next write
		plan.push_back(cfg_row(8'd1));
		plan.push_back(chk_row(OP_PUSH,  8'h80,
			'{1'b1, 8'h00, 1'b0, 1'b1, 8'd1, 8'd0, 1'b0}));
		plan.push_back(chk_row(OP_PUSH,  8'h22,
			'{1'b0, 8'h00, 1'b0, 1'b1, 8'd1, 8'd0, 1'b1}));
		// size 3: write drops the flag, fill, overflow, pointer wrap
		plan.push_back(cfg_row(8'd3));
		plan.push_back(cmd_row(OP_PUSH,  8'h01));
		plan.push_back(cmd_row(OP_PUSH,  8'h02));
		plan.push_back(chk_row(OP_PUSH,  8'h03,
			'{1'b0, 8'h00, 1'b0, 1'b1, 8'd2, 8'd0, 1'b1}));
		plan.push_back(cmd_row(OP_POP,   8'h00));
		plan.push_back(cmd_row(OP_PUSH,  8'h04));
		plan.push_back(cmd_row(OP_POP,   8'h00));
		plan.push_back(cmd_row(OP_POP,   8'h00));
		plan.push_back(cfg_row(8'd255));
		plan.push_back(cmd_row(OP_PUSH,  8'h7F));
		plan.push_back(cmd_row(OP_POP,   8'h00));

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_ring_size(plan[i].cfg_val);
			else
				issue_cmd(plan[i].op, plan[i].data, plan[i].pinned, plan[i].exp);
		end

		// random phases, extremes of the size register among them
		phase_size[0] = 8'd2;
		phase_size[1] = 8'd0;
		phase_size[2] = 8'd255;
		phase_size[3] = 8'd1;
		phase_size[4] = 8'd3;
		phase_size[5] = 8'($urandom_range(4, 16));
		phase_size[6] = 8'($urandom_range(17, 200));
		phase_size[7] = 8'd254;

		foreach (phase_size[p]) begin
			write_ring_size(phase_size[p]);
			n_items = (phase_size[p] >= 200) ? 500 : 100;
			filling = 1'b1;
			for (int i = 0; i < n_items; i++) begin
				if (i % 64 == 0)
					steady = ($urandom_range(0, 3) == 0);
				// in odd phases, hold the sender mid-phase until everything is back
				if (p % 2 == 1 && i == n_items / 2)
					drain();
				// run toward full, then toward empty, and over the edge
				span = ring_span();
				if ((wr_ptr + 1) % span == rd_ptr)
					filling = 1'b0;
				else if (wr_ptr == rd_ptr)
					filling = 1'b1;
				r = $urandom_range(0, 999);
				if (r < 4)
					o = OP_CLEAR;
				else if (r < 70)
					o = OP_PEEK;
				else if (r < 870)
					o = filling ? OP_PUSH : OP_POP;
				else
					o = filling ? OP_POP : OP_PUSH;
				issue_cmd(o, 8'($urandom_range(0, 255)), 1'b0, '0);
			end
		end
		steady = 1'b0;

		drain();
		repeat (RSP_LAT + 4) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$error("%0d responses never arrived", pending_rsp.size());
			n_fail++;
		end

		$display("ran %0d commands across %0d ring size writes", n_cmds, n_sizes);
		$display("saw %0d rejected pushes and %0d full-ring states", n_overflows, n_full);
		if (n_fail == 0) begin
			$display("byte_ring_fifo_tb: PASS");
		end else begin
			$display("byte_ring_fifo_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/brf_pkg.sv
hdl/brf_ram.sv
hdl/brf_ctrl.sv
hdl/byte_ring_fifo.sv
hdl/brf_checker.sv
tb/byte_ring_fifo_tb.sv
